@@ sv/assert_macros.svh @@
// Assertion macros for the RTL, used by the top-level file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ sv/aafc_pkg.sv @@
// Types, constants and fixed-point helpers for the box culling block.
package aafc_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_BITS  = 2 * WORD_BITS;
  localparam int DIVN_BITS  = WORD_BITS + FRAC_BITS;
  localparam int DCNT_BITS  = $clog2(DIVN_BITS + 1);
  localparam int ADDR_BITS  = 6;
  localparam int MEM_DEPTH  = 1 << ADDR_BITS;
  localparam int ADDR_MD    = 16;
  localparam int ADDR_BOX   = 32;
  localparam int ADDR_M     = 48;
  localparam int ELEM_COUNT = 38;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        umag_t;
  typedef logic [PROD_BITS-1:0]        wide_t;

  localparam word_t WORD_MAX   = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN   = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t FX_ONE     = word_t'(64'd1 << FRAC_BITS);
  localparam word_t FX_NEG_ONE = -FX_ONE;
  localparam word_t BOUND_INIT = FX_ONE + (FX_ONE >>> 1);
  localparam wide_t ROUND_HALF = wide_t'(64'd1 << (FRAC_BITS - 1));
  localparam wide_t LIM_POS    = wide_t'(WORD_MAX);
  localparam wide_t LIM_NEG    = LIM_POS + wide_t'(1);

  typedef struct packed {
    logic  sat;
    word_t val;
  } sat_word_t;

  typedef struct packed {
    logic  start;
    word_t num;
    word_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    logic  sat;
    word_t quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BOX, S_RA, S_RB, S_MUL, S_ACC, S_PT, S_DIV, S_DWAIT, S_OUT
  } seq_state_t;

  typedef enum logic {PH_MAT, PH_XF} phase_t;

  function automatic umag_t mag_of(word_t a);
    return a[WORD_BITS-1] ? umag_t'(-a) : umag_t'(a);
  endfunction

  // Signed word from sign and magnitude, clamped to the word range.
  function automatic sat_word_t from_mag(wide_t mag, logic neg);
    sat_word_t res;
    wide_t     lim;
    lim = neg ? LIM_NEG : LIM_POS;
    if (mag > lim) begin
      res.sat = 1'b1;
      res.val = neg ? WORD_MIN : WORD_MAX;
    end else begin
      res.sat = 1'b0;
      res.val = neg ? -word_t'(mag[WORD_BITS-1:0]) : word_t'(mag[WORD_BITS-1:0]);
    end
    return res;
  endfunction

  function automatic sat_word_t sat_add(word_t a, word_t b);
    sat_word_t             res;
    logic [WORD_BITS:0]    s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    res.sat = s[WORD_BITS] != s[WORD_BITS-1];
    res.val = res.sat ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : word_t'(s[WORD_BITS-1:0]);
    return res;
  endfunction

  function automatic sat_word_t sat_sub(word_t a, word_t b);
    sat_word_t             res;
    logic [WORD_BITS:0]    s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    res.sat = s[WORD_BITS] != s[WORD_BITS-1];
    res.val = res.sat ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : word_t'(s[WORD_BITS-1:0]);
    return res;
  endfunction

  // Product magnitude rounded to nearest (ties away from zero), then clamped.
  function automatic sat_word_t round_prod(wide_t mag, logic neg);
    wide_t s;
    s = mag + ROUND_HALF;
    return from_mag(s >> FRAC_BITS, neg);
  endfunction

endpackage

@@ sv/aafc_in_if.sv @@
// Input channel: load or evaluate transactions.
interface aafc_in_if;
  import aafc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [ADDR_BITS-1:0] element_index;
  word_t                element_value;
  modport source (output valid, op, element_index, element_value, input ready);
  modport sink   (input valid, op, element_index, element_value, output ready);
endinterface

@@ sv/aafc_out_if.sv @@
// Result channel: visibility and saturation flags.
interface aafc_out_if;
  logic valid;
  logic ready;
  logic visible;
  logic saturated;
  modport source (output valid, visible, saturated, input ready);
  modport sink   (input valid, visible, saturated, output ready);
endinterface

@@ sv/aafc_div.sv @@
// Restoring divider for fixed-point quotients, one quotient bit per cycle.
module aafc_div
  import aafc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic                 fin_r;
  logic [DCNT_BITS-1:0] cnt_r;
  logic [WORD_BITS:0]   rem_r;
  logic [DIVN_BITS-1:0] q_r;
  logic [DIVN_BITS-1:0] n_r;
  umag_t                d_r;
  logic                 neg_r;
  div_rsp_t             rsp_r;

  logic [WORD_BITS:0]   rem2;
  logic                 take;
  logic [WORD_BITS+1:0] twice;
  wide_t                qfin;
  sat_word_t            res;

  always_comb begin
    rem2  = {rem_r[WORD_BITS-1:0], n_r[DIVN_BITS-1]};
    take  = rem2 >= {1'b0, d_r};
    twice = {rem_r, 1'b0};
    qfin  = wide_t'(q_r) + wide_t'(twice >= {2'b00, d_r});
    res   = from_mag(qfin, neg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      fin_r    <= 1'b0;
      rsp_r.done <= 1'b0;
    end else begin
      rsp_r.done <= 1'b0;
      if (req.start) begin
        neg_r <= req.num[WORD_BITS-1] != req.den[WORD_BITS-1];
        if (req.den == '0) begin
          rsp_r.done <= 1'b1;
          rsp_r.sat  <= 1'b1;
          rsp_r.quo  <= req.num[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= DCNT_BITS'(DIVN_BITS);
          rem_r  <= '0;
          q_r    <= '0;
          n_r    <= {mag_of(req.num), {FRAC_BITS{1'b0}}};
          d_r    <= mag_of(req.den);
        end
      end else if (busy_r) begin
        rem_r <= take ? rem2 - {1'b0, d_r} : rem2;
        q_r   <= {q_r[DIVN_BITS-2:0], take};
        n_r   <= n_r << 1;
        cnt_r <= cnt_r - DCNT_BITS'(1);
        if (cnt_r == DCNT_BITS'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r      <= 1'b0;
        rsp_r.done <= 1'b1;
        rsp_r.sat  <= res.sat;
        rsp_r.quo  <= res.val;
      end
    end
  end

  assign rsp = rsp_r;

endmodule

@@ sv/aabb_frustum_cull_top.sv @@
// Top level of the clip-space box frustum culling block.
// Loads write one element each (indexes past 37 are dropped) into a 64-word
// memory with a registered read. An evaluation runs a sequencer over that
// memory: 6 box reads, 64 matrix products (two operand reads each through
// the single read port) written back as the product matrix, then per corner
// a corner-point step, 16 products and three quotients from a bit-serial
// divider, and a final state that hands the result to the output register
// once it is free. The divider dominates the evaluation time.
// The result waits in an output register while further transactions are taken.
`include "assert_macros.svh"
module aabb_frustum_cull_top
  import aafc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  aafc_in_if.sink    in_ch,
  aafc_out_if.source out_ch
);

  logic [WORD_BITS-1:0] mem [MEM_DEPTH];
  logic                 we;
  logic [ADDR_BITS-1:0] wr_addr;
  word_t                wr_data;
  logic [ADDR_BITS-1:0] rd_addr;
  word_t                rd_data_r;

  seq_state_t state_r, state_nxt;
  phase_t     phase_r;
  logic [1:0] c_r, r_r, k_r, dk_r;
  logic [2:0] corner_r, bcnt_r;
  word_t      box_r [6];
  word_t      p_r [3];
  word_t      v_r [4];
  word_t      mn_r [3];
  word_t      mx_r [3];
  word_t      opa_r, acc_r;
  wide_t      mul_r;
  logic       neg_r, sat_flag_r;
  logic       out_valid_r, visible_r, saturated_r;

  div_req_t   div_req;
  div_rsp_t   div_rsp;

  word_t      opb;
  sat_word_t  prod, sum, pt [3];
  logic       in_fire, out_free, vis;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  aafc_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  always_comb begin
    opb = (phase_r == PH_MAT) ? rd_data_r : ((k_r == 2'd3) ? FX_ONE : p_r[k_r]);
    prod = round_prod(mul_r, neg_r);
    sum  = sat_add((k_r == 2'd0) ? '0 : acc_r, prod.val);
    for (int i = 0; i < 3; i++) begin
      pt[i] = corner_r[2-i] ? sat_sub(box_r[i], box_r[3+i]) : sat_add(box_r[i], box_r[3+i]);
    end
    vis = !(mn_r[2] > FX_ONE || mx_r[2] < 0 || mn_r[0] > FX_ONE || mx_r[0] < FX_NEG_ONE ||
            mn_r[1] > FX_ONE || mx_r[1] < FX_NEG_ONE);
  end

  // Next state, memory port and divider control.
  always_comb begin
    state_nxt   = state_r;
    we          = 1'b0;
    wr_addr     = in_ch.element_index;
    wr_data     = in_ch.element_value;
    rd_addr     = ADDR_BITS'(ADDR_BOX) + ADDR_BITS'(bcnt_r);
    in_ch.ready = state_r == S_IDLE;
    div_req.start = 1'b0;
    div_req.num   = v_r[dk_r];
    div_req.den   = v_r[3];
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.op) begin
            state_nxt = S_BOX;
          end else begin
            we = in_ch.element_index < ADDR_BITS'(ELEM_COUNT);
          end
        end
      end
      S_BOX: begin
        if (bcnt_r == 3'd6) begin
          state_nxt = S_RA;
        end
      end
      S_RA: begin
        rd_addr   = (phase_r == PH_MAT) ? {2'b00, k_r, r_r}
                                        : ADDR_BITS'(ADDR_M) + {2'b00, k_r, r_r};
        state_nxt = S_RB;
      end
      S_RB: begin
        rd_addr   = ADDR_BITS'(ADDR_MD) + {2'b00, c_r, k_r};
        state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        if (k_r != 2'd3) begin
          state_nxt = S_RA;
        end else if (phase_r == PH_MAT) begin
          we      = 1'b1;
          wr_addr = ADDR_BITS'(ADDR_M) + {2'b00, c_r, r_r};
          wr_data = sum.val;
          state_nxt = (c_r == 2'd3 && r_r == 2'd3) ? S_PT : S_RA;
        end else begin
          state_nxt = (r_r == 2'd3) ? S_DIV : S_RA;
        end
      end
      S_PT: state_nxt = S_RA;
      S_DIV: begin
        div_req.start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_rsp.done) begin
          if (dk_r != 2'd2) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = (corner_r == 3'd7) ? S_OUT : S_PT;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        bcnt_r     <= '0;
        phase_r    <= PH_MAT;
        c_r        <= '0;
        r_r        <= '0;
        k_r        <= '0;
        corner_r   <= '0;
        sat_flag_r <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          mn_r[i] <= BOUND_INIT;
          mx_r[i] <= -BOUND_INIT;
        end
      end
      S_BOX: begin
        bcnt_r <= bcnt_r + 3'd1;
        if (bcnt_r != 3'd0) begin
          box_r[bcnt_r - 3'd1] <= rd_data_r;
        end
      end
      S_RB: opa_r <= rd_data_r;
      S_MUL: begin
        mul_r <= wide_t'(mag_of(opa_r)) * wide_t'(mag_of(opb));
        neg_r <= opa_r[WORD_BITS-1] != opb[WORD_BITS-1];
      end
      S_ACC: begin
        acc_r      <= sum.val;
        sat_flag_r <= sat_flag_r | prod.sat | sum.sat;
        k_r        <= k_r + 2'd1;
        if (k_r == 2'd3) begin
          r_r <= r_r + 2'd1;
          if (phase_r == PH_MAT) begin
            if (r_r == 2'd3) begin
              c_r <= c_r + 2'd1;
              if (c_r == 2'd3) begin
                phase_r <= PH_XF;
              end
            end
          end else begin
            v_r[r_r] <= sum.val;
            dk_r     <= '0;
          end
        end
      end
      S_PT: begin
        for (int i = 0; i < 3; i++) begin
          p_r[i] <= pt[i].val;
        end
        sat_flag_r <= sat_flag_r | pt[0].sat | pt[1].sat | pt[2].sat;
        r_r <= '0;
        k_r <= '0;
      end
      S_DWAIT: begin
        if (div_rsp.done) begin
          sat_flag_r <= sat_flag_r | div_rsp.sat;
          if (div_rsp.quo < mn_r[dk_r]) begin
            mn_r[dk_r] <= div_rsp.quo;
          end
          if (div_rsp.quo > mx_r[dk_r]) begin
            mx_r[dk_r] <= div_rsp.quo;
          end
          dk_r <= dk_r + 2'd1;
          if (dk_r == 2'd2) begin
            corner_r <= corner_r + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
        visible_r   <= vis;
        saturated_r <= sat_flag_r;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.visible   = visible_r;
  assign out_ch.saturated = saturated_r;

  `ASSERT_IMPL(a_out_from_seq, clk, rst_n, $rose(out_valid_r), $past(state_r == S_OUT), "result without finished evaluation")
  `ASSERT_IMPL(a_div_done_wait, clk, rst_n, div_rsp.done, state_r == S_DWAIT, "quotient while not waiting")
  `ASSERT_IMPL(a_load_range, clk, rst_n, we && state_r == S_IDLE, wr_addr < ADDR_BITS'(ELEM_COUNT), "load beyond element range")

endmodule

@@ bench/tb_aabb_frustum_cull_top.sv @@
// Self-checking bench for the box frustum culling block: directed rows, then random load/evaluate runs.
`timescale 1ns / 1ps
module tb_aabb_frustum_cull_top;
  import aafc_pkg::*;

  localparam int IDX_MD  = 16;
  localparam int IDX_ORG = 32;
  localparam int IDX_EXT = 35;
  localparam word_t Q_ONE  = 32'sh0001_0000;
  localparam word_t Q_HALF = 32'sh0000_8000;
  localparam word_t Q_1P5  = 32'sh0001_8000;

  typedef enum logic {OP_LOAD = 1'b0, OP_EVAL = 1'b1} op_e;

  typedef struct packed {
    logic visible;
    logic saturated;
  } cull_flags_t;

  typedef struct {
    op_e         op;
    int          idx;
    word_t       val;
    bit          typed;
    cull_flags_t flags;
  } stim_row_t;

  logic clk;
  logic rst_n;
  aafc_in_if  in_ch();
  aafc_out_if out_ch();

  aabb_frustum_cull_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Local copy of the element stores.
  word_t vp_mem [16];
  word_t md_mem [16];
  word_t box_mem [6];
  bit    clamp_seen;

  cull_flags_t flags_due [$];
  int          errors;
  int          burst_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic word_t clamp_mag(input bit neg, input longint unsigned m);
    longint unsigned lim;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (m > lim) begin
      clamp_seen = 1'b1;
      return neg ? WORD_MIN : WORD_MAX;
    end
    return neg ? word_t'(-longint'(m)) : word_t'(m);
  endfunction

  function automatic word_t clamp_wide(input longint s);
    if (s > longint'(WORD_MAX)) begin
      clamp_seen = 1'b1;
      return WORD_MAX;
    end
    if (s < longint'(WORD_MIN)) begin
      clamp_seen = 1'b1;
      return WORD_MIN;
    end
    return word_t'(s);
  endfunction

  function automatic word_t q_mul(input word_t a, input word_t b);
    longint          p;
    longint unsigned m;
    p = longint'(a) * longint'(b);
    m = p < 0 ? longint'(-p) : p;
    m = (m + 64'd32768) >> FRAC_BITS;
    return clamp_mag((a < 0) != (b < 0), m);
  endfunction

  function automatic word_t q_add(input word_t a, input word_t b);
    return clamp_wide(longint'(a) + longint'(b));
  endfunction

  // Quotient rounded to nearest, ties away from zero; a zero divisor clamps.
  function automatic word_t q_div(input word_t a, input word_t w);
    longint unsigned n, d, q, r;
    if (w == 0) begin
      clamp_seen = 1'b1;
      return a < 0 ? WORD_MIN : WORD_MAX;
    end
    n = (a < 0 ? longint'(-longint'(a)) : longint'(a)) << FRAC_BITS;
    d = w < 0 ? longint'(-longint'(w)) : longint'(w);
    q = n / d;
    r = n % d;
    if (r >= d - r) q++;
    return clamp_mag((a < 0) != (w < 0), q);
  endfunction

  function automatic cull_flags_t cull_box();
    word_t       m [16];
    word_t       lo [3];
    word_t       hi [3];
    word_t       pt [3];
    word_t       v [4];
    word_t       acc, q;
    cull_flags_t f;
    clamp_seen = 1'b0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = q_mul(vp_mem[r], md_mem[c*4]);
        for (int k = 1; k < 4; k++) acc = q_add(acc, q_mul(vp_mem[k*4+r], md_mem[c*4+k]));
        m[c*4+r] = acc;
      end
    end
    for (int k = 0; k < 3; k++) begin
      lo[k] = Q_1P5;
      hi[k] = -Q_1P5;
    end
    for (int corner = 0; corner < 8; corner++) begin
      for (int k = 0; k < 3; k++) begin
        if ((corner >> (2 - k)) & 1)
          pt[k] = clamp_wide(longint'(box_mem[k]) - longint'(box_mem[3+k]));
        else
          pt[k] = q_add(box_mem[k], box_mem[3+k]);
      end
      for (int r = 0; r < 4; r++) begin
        acc = q_mul(m[r], pt[0]);
        acc = q_add(acc, q_mul(m[4+r], pt[1]));
        acc = q_add(acc, q_mul(m[8+r], pt[2]));
        v[r] = q_add(acc, q_mul(m[12+r], Q_ONE));
      end
      for (int k = 0; k < 3; k++) begin
        q = q_div(v[k], v[3]);
        if (q < lo[k]) lo[k] = q;
        if (q > hi[k]) hi[k] = q;
      end
    end
    f.visible = !(lo[2] > Q_ONE || hi[2] < 0 || lo[0] > Q_ONE || hi[0] < -Q_ONE ||
                  lo[1] > Q_ONE || hi[1] < -Q_ONE);
    f.saturated = clamp_seen;
    return f;
  endfunction

  // Drives one transaction and returns once it has been taken; bursts and gaps
  // are inserted before the next one.
  task automatic send(input op_e op, input int idx, input word_t val, input bit typed,
                      input cull_flags_t flags);
    cull_flags_t got;
    int          gap;
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.element_index <= idx[ADDR_BITS-1:0];
    in_ch.element_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_LOAD) begin
      if (idx < IDX_MD) vp_mem[idx] = val;
      else if (idx < IDX_ORG) md_mem[idx-IDX_MD] = val;
      else if (idx < 38) box_mem[idx-IDX_ORG] = val;
    end else begin
      got = cull_box();
      if (typed && got != flags)
        report_mismatch($sformatf("predictor gives %b, table row expects %b", got, flags));
      flags_due = {flags_due, (typed ? flags : got)};
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(0, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: samples at the edge, then picks ready for the next cycle.
  int   stall_mode = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  int   rx_cycle;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (flags_due.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        if (out_ch.visible !== flags_due[0].visible)
          report_mismatch($sformatf("visible %b, want %b", out_ch.visible, flags_due[0].visible));
        if (out_ch.saturated !== flags_due[0].saturated)
          report_mismatch($sformatf("saturated %b, want %b", out_ch.saturated,
                                    flags_due[0].saturated));
        void'(flags_due.pop_front());
      end
    end
    rx_cycle++;
    if (rx_cycle % 500 == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_pat  = $urandom;
    end
    out_ch.ready <= (stall_mode == 0) ? 1'b1 : stall_pat[rx_cycle % 16];
  end

  function automatic word_t pick_value();
    case ($urandom_range(0, 9))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return 0;
      3:       return $urandom;
      4:       return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
      default: return word_t'(int'($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  stim_row_t   rows [$];
  cull_flags_t none_f;
  int          sent;

  task automatic add_row(input op_e op, input int idx, input word_t val, input bit typed,
                         input logic vis, input logic sat);
    stim_row_t r;
    r.op = op; r.idx = idx; r.val = val; r.typed = typed;
    r.flags.visible = vis; r.flags.saturated = sat;
    rows = {rows, r};
  endtask

  initial begin
    int k, n_loads;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.op            = OP_LOAD;
    in_ch.element_index = '0;
    in_ch.element_value = '0;
    none_f = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity matrices and a unit box around the origin.
    for (int i = 0; i < 38; i++) begin
      if (i < IDX_ORG) send(OP_LOAD, i, (i % 16) % 5 == 0 ? Q_ONE : 0, 0, none_f);
      else send(OP_LOAD, i, i >= IDX_EXT ? Q_HALF : 0, 0, none_f);
    end

    add_row(OP_EVAL, 0, 0, 1, 1, 0);
    add_row(OP_LOAD, IDX_ORG, 32'sh000A_0000, 0, 0, 0);
    add_row(OP_EVAL, 0, 0, 1, 0, 0);
    add_row(OP_LOAD, IDX_ORG, WORD_MAX, 0, 0, 0);
    add_row(OP_EVAL, 0, 0, 1, 0, 1);
    add_row(OP_LOAD, IDX_ORG, WORD_MIN, 0, 0, 0);
    add_row(OP_EVAL, 0, 0, 1, 0, 1);
    add_row(OP_LOAD, IDX_ORG, 0, 0, 0, 0);
    // Zero w: every quotient clamps, the box spans the whole volume.
    add_row(OP_LOAD, 15, 0, 0, 0, 0);
    add_row(OP_EVAL, 0, 0, 1, 1, 1);
    add_row(OP_LOAD, 15, Q_ONE, 0, 0, 0);
    // Indexes past the store are dropped.
    add_row(OP_LOAD, 40, WORD_MIN, 0, 0, 0);
    add_row(OP_LOAD, 63, 32'sh5555_AAAA, 0, 0, 0);
    add_row(OP_EVAL, 0, 0, 1, 1, 0);
    add_row(OP_LOAD, IDX_ORG + 2, -32'sh0005_0000, 0, 0, 0);
    add_row(OP_EVAL, 0, 0, 1, 0, 0);
    add_row(OP_LOAD, IDX_ORG + 2, 0, 0, 0, 0);
    add_row(OP_LOAD, IDX_MD, WORD_MIN, 0, 0, 0);
    add_row(OP_EVAL, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, 0, WORD_MAX, 0, 0, 0);
    add_row(OP_EVAL, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, IDX_EXT + 1, WORD_MAX, 0, 0, 0);
    add_row(OP_EVAL, 0, 0, 0, 0, 0);
    foreach (rows[i]) send(rows[i].op, rows[i].idx, rows[i].val, rows[i].typed, rows[i].flags);

    // Hold off until the block has drained.
    in_ch.valid <= 1'b0;
    wait (flags_due.size() == 0);
    @(posedge clk);

    sent = 0;
    while (sent < 340) begin
      k = $urandom_range(0, 9);
      if (k < 7) begin
        // Rewrite a random subset of elements, then evaluate.
        n_loads = $urandom_range(1, 12);
        repeat (n_loads) begin
          send(OP_LOAD, $urandom_range(0, 37), pick_value(), 0, none_f);
          sent++;
        end
        send(OP_EVAL, $urandom_range(0, 63), $urandom, 0, none_f);
        sent++;
      end else if (k < 9) begin
        send(OP_LOAD, $urandom_range(38, 63), $urandom, 0, none_f);
        sent++;
      end else begin
        send(OP_EVAL, $urandom_range(0, 63), $urandom, 0, none_f);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;

    wait (flags_due.size() == 0);
    repeat (2100) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
